>>> rtl/ffea_pkg.sv
package ffea_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int ALU_W = 34;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_OVERLAP = 3'd3,
    ST_NOFIT   = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR,
    S_A_RD, S_A_CHK, S_A_DEC, S_A_WR,
    S_F_END, S_F_RCHK, S_F_RDEC, S_F_RD, S_F_CHK, S_F_DEC,
    S_F_PEND, S_F_PCMP, S_F_NCMP, S_F_NDEC, S_F_MRG, S_F_MW, S_F_BW,
    S_S_RD, S_S_CHK, S_S_LINK,
    S_FT, S_FTW, S_DONE
  } state_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_op_t;

endpackage

>>> rtl/first_fit_extent_allocator_core.sv
// Allocate walks the free list one extent at a time; free walks the list, then scans
// the pool for an unused node when the block merges with no neighbour; clear resets
// every valid entry and node 0. One item at a time: busy stays high until the strobe.
// Steps share the node and valid memories (one read and one write port each) and the
// single adder. Synchronous reset runs a clearing pass (busy high, no result);
// results appear for one cycle on out_strobe and the receiver cannot stall them.
module first_fit_extent_allocator_core #(
  parameter int ENTRIES = ffea_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_block_size,
  input  logic [31:0] in_block_offset,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [31:0] out_alloc_offset,
  output logic [31:0] out_free_space
);
  import ffea_pkg::*;

  logic [31:0] region_len_r;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : region_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_len_r <= 32'd65536;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      region_len_r <= pwdata;
    end
  end

  ffea_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .region_len(region_len_r),
    .start(start), .busy(busy),
    .in_func(in_func), .in_block_size(in_block_size), .in_block_offset(in_block_offset),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_alloc_offset(out_alloc_offset), .out_free_space(out_free_space)
  );

endmodule

>>> rtl/ffea_ram.sv
module ffea_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ffea_alu.sv
module ffea_alu (
  input  ffea_pkg::alu_op_t            op,
  output logic [ffea_pkg::ALU_W-1:0]   res
);
  import ffea_pkg::*;

  // two's complement subtract when sub is set; top bit is the borrow/sign
  assign res = op.a + (op.b ^ {ALU_W{op.sub}}) + ALU_W'(op.sub);

endmodule

>>> rtl/ffea_ctrl.sv
module ffea_ctrl #(
  parameter int ENTRIES = ffea_pkg::ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [31:0]             region_len,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_func,
  input  logic [31:0]             in_block_size,
  input  logic [31:0]             in_block_offset,
  output logic                    out_strobe,
  output logic [2:0]              out_status,
  output logic [31:0]             out_alloc_offset,
  output logic [31:0]             out_free_space
);
  import ffea_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = $clog2(ENTRIES + 1);
  localparam int NW = 64 + PW;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [1:0]       func_r;
  logic [31:0]      size_r, off_r, ft_r, grant_r;
  logic [32:0]      end_r;
  logic [PW-1:0]    head_r, n_r, prev_r, prev_link_r, cur_link_r;
  logic [31:0]      prev_start_r, prev_len_r, cur_start_r, cur_len_r;
  logic [IW-1:0]    i_r;
  logic             mprev_r, mnext_r, op_r;
  status_t          status_r;
  logic [ALU_W-1:0] acc_r;

  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_res;

  logic             node_we, val_we, val_wdata;
  logic [IW-1:0]    node_waddr, node_raddr, val_waddr, val_raddr;
  logic [NW-1:0]    node_wdata, node_rdata;
  logic             val_rdata;
  logic [31:0]      rd_start, rd_len;
  logic [PW-1:0]    rd_link;

  logic             acc_neg, acc_zero, prev_ok, n_ok;

  ffea_alu u_alu (.op(alu_op), .res(alu_res));

  ffea_ram #(.W(NW), .D(ENTRIES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  ffea_ram #(.W(1), .D(ENTRIES)) u_valid_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(val_raddr), .rdata(val_rdata)
  );

  assign rd_start = node_rdata[NW-1 -: 32];
  assign rd_len   = node_rdata[NW-33 -: 32];
  assign rd_link  = node_rdata[PW-1:0];
  assign acc_neg  = acc_r[ALU_W-1];
  assign acc_zero = (acc_r == '0);
  assign prev_ok  = (prev_r != NIL);
  assign n_ok     = (n_r != NIL);

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = (state_r == S_DONE);
  assign out_status       = status_r;
  assign out_alloc_offset = grant_r;
  assign out_free_space   = ft_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (func_t'(in_func))
            FN_ALLOC: state_nxt = (in_block_size == '0) ? S_DONE : S_A_RD;
            FN_FREE:  state_nxt = (in_block_size == '0) ? S_DONE : S_F_END;
            FN_CLEAR: state_nxt = S_CLR;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_CLR:    if (i_r == LAST) state_nxt = op_r ? S_DONE : S_IDLE;
      S_A_RD:   state_nxt = n_ok ? S_A_CHK : S_DONE;
      S_A_CHK:  state_nxt = S_A_DEC;
      S_A_DEC: begin
        if (acc_neg) state_nxt = S_A_RD;
        else if (acc_zero) state_nxt = S_FT;
        else state_nxt = S_A_WR;
      end
      S_A_WR:   state_nxt = S_FT;
      S_F_END:  state_nxt = S_F_RCHK;
      S_F_RCHK: state_nxt = S_F_RDEC;
      S_F_RDEC: state_nxt = acc_neg ? S_DONE : S_F_RD;
      S_F_RD:   state_nxt = n_ok ? S_F_CHK : S_F_PEND;
      S_F_CHK:  state_nxt = S_F_DEC;
      S_F_DEC:  state_nxt = acc_neg ? S_F_RD : S_F_PEND;
      S_F_PEND: state_nxt = S_F_PCMP;
      S_F_PCMP: state_nxt = S_F_NCMP;
      S_F_NCMP: state_nxt = (prev_ok && acc_neg) ? S_DONE : S_F_NDEC;
      S_F_NDEC: begin
        if (n_ok && acc_neg) state_nxt = S_DONE;
        else if (mprev_r || (n_ok && acc_zero)) state_nxt = S_F_MRG;
        else state_nxt = S_S_RD;
      end
      S_F_MRG:  state_nxt = S_F_MW;
      S_F_MW:   state_nxt = (mprev_r && mnext_r) ? S_F_BW : S_FT;
      S_F_BW:   state_nxt = S_FT;
      S_S_RD:   state_nxt = S_S_CHK;
      S_S_CHK: begin
        if (!val_rdata) state_nxt = S_S_LINK;
        else if (i_r == LAST) state_nxt = S_DONE;
        else state_nxt = S_S_RD;
      end
      S_S_LINK: state_nxt = S_FT;
      S_FT:     state_nxt = S_FTW;
      S_FTW:    state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory ports and shared adder operands
  always_comb begin
    node_we    = 1'b0;
    node_waddr = n_r[IW-1:0];
    node_wdata = '0;
    node_raddr = n_r[IW-1:0];
    val_we     = 1'b0;
    val_waddr  = n_r[IW-1:0];
    val_wdata  = 1'b0;
    val_raddr  = i_r;
    alu_op     = '0;
    case (state_r)
      S_CLR: begin
        val_we    = 1'b1;
        val_waddr = i_r;
        val_wdata = (i_r == '0);
        if (i_r == '0) begin
          node_we    = 1'b1;
          node_waddr = '0;
          node_wdata = {32'd0, region_len, NIL};
        end
      end
      S_A_CHK: alu_op = '{a: ALU_W'(rd_len), b: ALU_W'(size_r), sub: 1'b1};
      S_A_DEC: begin
        alu_op = '{a: ALU_W'(cur_start_r), b: ALU_W'(size_r), sub: 1'b0};
        if (!acc_neg && acc_zero) begin
          val_we = 1'b1;
          if (prev_ok) begin
            node_we    = 1'b1;
            node_waddr = prev_r[IW-1:0];
            node_wdata = {prev_start_r, prev_len_r, cur_link_r};
          end
        end
      end
      S_A_WR: begin
        node_we    = 1'b1;
        node_wdata = {acc_r[31:0], cur_len_r, cur_link_r};
      end
      S_F_END:  alu_op = '{a: ALU_W'(off_r), b: ALU_W'(size_r), sub: 1'b0};
      S_F_RCHK: alu_op = '{a: ALU_W'(region_len), b: acc_r, sub: 1'b1};
      S_F_CHK:  alu_op = '{a: ALU_W'(rd_start), b: ALU_W'(off_r), sub: 1'b1};
      S_F_PEND: alu_op = '{a: ALU_W'(prev_start_r), b: ALU_W'(prev_len_r), sub: 1'b0};
      S_F_PCMP: alu_op = '{a: ALU_W'(off_r), b: acc_r, sub: 1'b1};
      S_F_NCMP: alu_op = '{a: ALU_W'(cur_start_r), b: ALU_W'(end_r), sub: 1'b1};
      S_F_MRG:  alu_op = '{a: ALU_W'(mprev_r ? prev_len_r : cur_len_r),
                           b: ALU_W'(size_r), sub: 1'b0};
      S_F_MW: begin
        alu_op = '{a: acc_r, b: ALU_W'(cur_len_r), sub: 1'b0};
        if (!(mprev_r && mnext_r)) begin
          node_we = 1'b1;
          if (mprev_r) begin
            node_waddr = prev_r[IW-1:0];
            node_wdata = {prev_start_r, acc_r[31:0], prev_link_r};
          end else begin
            node_wdata = {off_r, acc_r[31:0], cur_link_r};
          end
        end
      end
      S_F_BW: begin
        node_we    = 1'b1;
        node_waddr = prev_r[IW-1:0];
        node_wdata = {prev_start_r, acc_r[31:0], cur_link_r};
        val_we     = 1'b1;
      end
      S_S_CHK: begin
        if (!val_rdata) begin
          node_we    = 1'b1;
          node_waddr = i_r;
          node_wdata = {off_r, size_r, n_r};
          val_we     = 1'b1;
          val_waddr  = i_r;
          val_wdata  = 1'b1;
        end
      end
      S_S_LINK: begin
        if (prev_ok) begin
          node_we    = 1'b1;
          node_waddr = prev_r[IW-1:0];
          node_wdata = {prev_start_r, prev_len_r, PW'(i_r)};
        end
      end
      S_FT: alu_op = '{a: ALU_W'(ft_r), b: ALU_W'(size_r),
                       sub: (func_t'(func_r) == FN_ALLOC)};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      i_r     <= '0;
      op_r    <= 1'b0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= alu_res;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r   <= in_func;
            size_r   <= in_block_size;
            off_r    <= in_block_offset;
            grant_r  <= '0;
            status_r <= ST_OK;
            n_r      <= head_r;
            prev_r   <= NIL;
            mprev_r  <= 1'b0;
            mnext_r  <= 1'b0;
            i_r      <= '0;
            op_r     <= 1'b1;
            if (in_block_size == '0 &&
                (func_t'(in_func) == FN_ALLOC || func_t'(in_func) == FN_FREE)) begin
              status_r <= ST_ZERO;
            end
          end
        end
        S_CLR: begin
          i_r <= i_r + 1'b1;
          if (i_r == LAST) begin
            head_r <= '0;
            ft_r   <= region_len;
          end
        end
        S_A_RD: if (!n_ok) status_r <= ST_NOFIT;
        S_A_CHK: begin
          cur_start_r <= rd_start;
          cur_len_r   <= rd_len;
          cur_link_r  <= rd_link;
        end
        S_A_DEC: begin
          if (acc_neg) begin
            prev_r       <= n_r;
            prev_start_r <= cur_start_r;
            prev_len_r   <= cur_len_r;
            prev_link_r  <= cur_link_r;
            n_r          <= cur_link_r;
          end else begin
            grant_r   <= cur_start_r;
            cur_len_r <= acc_r[31:0];
            if (acc_zero && !prev_ok) head_r <= cur_link_r;
          end
        end
        S_F_RCHK: end_r <= acc_r[32:0];
        S_F_RDEC: if (acc_neg) status_r <= ST_RANGE;
        S_F_CHK: begin
          cur_start_r <= rd_start;
          cur_len_r   <= rd_len;
          cur_link_r  <= rd_link;
        end
        S_F_DEC: begin
          if (acc_neg) begin
            prev_r       <= n_r;
            prev_start_r <= cur_start_r;
            prev_len_r   <= cur_len_r;
            prev_link_r  <= cur_link_r;
            n_r          <= cur_link_r;
          end
        end
        S_F_NCMP: begin
          mprev_r <= prev_ok && acc_zero;
          if (prev_ok && acc_neg) status_r <= ST_OVERLAP;
        end
        S_F_NDEC: begin
          mnext_r <= n_ok && acc_zero;
          i_r     <= IW'(1);
          if (n_ok && acc_neg) status_r <= ST_OVERLAP;
        end
        S_S_CHK: begin
          if (val_rdata) begin
            if (i_r == LAST) status_r <= ST_FULL;
            else i_r <= i_r + 1'b1;
          end
        end
        S_S_LINK: if (!prev_ok) head_r <= PW'(i_r);
        S_FTW: ft_r <= acc_r[31:0];
        default: ;
      endcase
    end
  end

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe held");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item accepted but not busy");

  a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_alloc_offset == '0))
    else $error("offset reported on failed item");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= NIL) else $error("list head out of range");

endmodule

>>> tb/ffea_checker.sv
module ffea_checker #(
  parameter int ENTRIES = ffea_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_block_size,
  input  logic [31:0] in_block_offset,
  input  logic        out_strobe,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_alloc_offset,
  input  logic [31:0] out_free_space,
  output int          pending,
  output int          fails,
  output int          results_seen
);
  import ffea_pkg::*;

  localparam int NIL = ENTRIES;
  localparam logic [2:0] REG_REGION_LEN = 3'd0;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [31:0] space;
  } outcome_t;

  outcome_t    outcome_q[$];
  logic [31:0] region_size;
  logic [31:0] ext_start[ENTRIES];
  logic [31:0] ext_len[ENTRIES];
  int          ext_link[ENTRIES];
  bit          node_used[ENTRIES];
  int          head;
  logic [31:0] free_sum;

  initial begin
    fails = 0;
    results_seen = 0;
    pending = 0;
  end

  function automatic void drop_node(int n);
    node_used[n] = 1'b0;
    ext_start[n] = '0;
    ext_len[n]   = '0;
    ext_link[n]  = NIL;
  endfunction

  function automatic void rebuild_list();
    for (int i = 0; i < ENTRIES; i++) drop_node(i);
    node_used[0] = 1'b1;
    ext_len[0]   = region_size;
    head         = 0;
    free_sum     = region_size;
  endfunction

  function automatic outcome_t predict_outcome(func_t fn, logic [31:0] sz, logic [31:0] off);
    outcome_t    r;
    int          prv;
    int          cur;
    int          fresh;
    bit          hit;
    bit          mp;
    bit          mn;
    logic [32:0] blk_end;
    logic [32:0] prv_end;
    r.status = ST_OK;
    r.offset = '0;
    case (fn)
      FN_ALLOC: begin
        if (sz == 0) begin
          r.status = ST_ZERO;
        end else begin
          r.status = ST_NOFIT;
          prv = NIL;
          cur = head;
          hit = 1'b0;
          while (cur != NIL && !hit) begin
            if (ext_len[cur] >= sz) begin
              hit = 1'b1;
              r.status = ST_OK;
              r.offset = ext_start[cur];
              if (ext_len[cur] == sz) begin
                if (prv != NIL) ext_link[prv] = ext_link[cur];
                else head = ext_link[cur];
                drop_node(cur);
              end else begin
                ext_len[cur]   = ext_len[cur] - sz;
                ext_start[cur] = ext_start[cur] + sz;
              end
              free_sum = free_sum - sz;
            end else begin
              prv = cur;
              cur = ext_link[cur];
            end
          end
        end
      end
      FN_FREE: begin
        if (sz == 0) begin
          r.status = ST_ZERO;
        end else if (off > region_size || sz > region_size - off) begin
          r.status = ST_RANGE;
        end else begin
          prv = NIL;
          cur = head;
          while (cur != NIL && ext_start[cur] < off) begin
            prv = cur;
            cur = ext_link[cur];
          end
          blk_end = {1'b0, off} + sz;
          prv_end = '0;
          if (prv != NIL) prv_end = {1'b0, ext_start[prv]} + ext_len[prv];
          if (prv != NIL && prv_end > off) begin
            r.status = ST_OVERLAP;
          end else if (cur != NIL && blk_end > ext_start[cur]) begin
            r.status = ST_OVERLAP;
          end else begin
            mp = (prv != NIL) && (prv_end == off);
            mn = (cur != NIL) && (blk_end == ext_start[cur]);
            if (mp && mn) begin
              ext_len[prv]  = ext_len[prv] + sz + ext_len[cur];
              ext_link[prv] = ext_link[cur];
              drop_node(cur);
            end else if (mp) begin
              ext_len[prv] = ext_len[prv] + sz;
            end else if (mn) begin
              ext_start[cur] = off;
              ext_len[cur]   = ext_len[cur] + sz;
            end else begin
              // node 0 comes back only through clear
              fresh = NIL;
              for (int i = ENTRIES - 1; i >= 1; i--)
                if (!node_used[i]) fresh = i;
              if (fresh == NIL) begin
                r.status = ST_FULL;
              end else begin
                node_used[fresh] = 1'b1;
                ext_start[fresh] = off;
                ext_len[fresh]   = sz;
                ext_link[fresh]  = cur;
                if (prv != NIL) ext_link[prv] = fresh;
                else head = fresh;
              end
            end
            if (r.status == ST_OK) free_sum = free_sum + sz;
          end
        end
      end
      FN_CLEAR: rebuild_list();
      default: ;
    endcase
    r.space = free_sum;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s got 0x%08h want 0x%08h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    outcome_t o;
    if (!rst_n) begin
      outcome_q.delete();
      region_size = 32'd65536;
      rebuild_list();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_REGION_LEN)
        region_size = pwdata;
      if (out_strobe) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          $display("ERROR at %0t: result with no item outstanding", $time);
          fails++;
        end else begin
          o = outcome_q.pop_front();
          if (out_status != o.status)
            report_mismatch("status", 32'(out_status), 32'(o.status));
          if (out_alloc_offset != o.offset)
            report_mismatch("alloc_offset", out_alloc_offset, o.offset);
          if (out_free_space != o.space)
            report_mismatch("free_space", out_free_space, o.space);
        end
      end
      if (start && !busy)
        outcome_q.push_back(predict_outcome(func_t'(in_func), in_block_size, in_block_offset));
    end
    pending <= outcome_q.size();
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  import ffea_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_ITEMS = 65;

  typedef struct {
    logic [1:0]  fn;
    logic [31:0] sz;
  } sent_t;

  typedef struct {
    logic [31:0] off;
    logic [31:0] sz;
  } blk_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = '0;
  logic [31:0] in_block_size = '0;
  logic [31:0] in_block_offset = '0;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [31:0] out_alloc_offset;
  logic [31:0] out_free_space;

  int pending;
  int fails;
  int results_seen;
  int idle_cycles;
  int items_sent = 0;
  int settings_used = 0;
  bit no_gaps = 1'b0;

  sent_t inflight_q[$];
  blk_t  live_q[$];

  always #1 clk = ~clk;

  first_fit_extent_allocator_core u_top (.*);

  ffea_checker u_checker (.*);

  // track granted blocks so frees can target real allocations
  always @(posedge clk) begin : track
    sent_t s;
    if (rst_n) begin
      if (out_strobe && inflight_q.size() > 0) begin
        s = inflight_q.pop_front();
        if (s.fn == FN_ALLOC && out_status == ST_OK)
          live_q.push_back('{out_alloc_offset, s.sz});
        else if (s.fn == FN_CLEAR)
          live_q.delete();
      end
      if (start && !busy) inflight_q.push_back('{in_func, in_block_size});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no activity for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(func_t fn, logic [31:0] sz, logic [31:0] off);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn;
    in_block_size <= sz;
    in_block_offset <= off;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // write the region size, then clear so it takes effect
  task automatic set_region(logic [31:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    settings_used++;
    send_item(FN_CLEAR, $urandom, $urandom);
  endtask

  task automatic random_item(logic [31:0] rsz);
    int          r;
    int          idx;
    logic [31:0] lim;
    blk_t        b;
    r = $urandom_range(0, 99);
    lim = (rsz / 16 == 0) ? 32'd1 : rsz / 16;
    if (r < 2) begin
      send_item(FN_CLEAR, $urandom, $urandom);
    end else if (r < 4) begin
      send_item(FN_NONE, $urandom, $urandom);
    end else if (r < 45) begin
      r = $urandom_range(0, 99);
      if (r < 5) send_item(FN_ALLOC, 32'd0, $urandom);
      else if (r < 10) send_item(FN_ALLOC, $urandom, $urandom);
      else if (r < 13) send_item(FN_ALLOC, rsz, $urandom);
      else send_item(FN_ALLOC, $urandom_range(1, lim), $urandom);
    end else if (live_q.size() > 0 && r < 90) begin
      idx = $urandom_range(0, live_q.size() - 1);
      b = live_q[idx];
      if ($urandom_range(0, 9) != 0) live_q.delete(idx);
      if (b.sz > 1 && $urandom_range(0, 3) == 0) begin
        // release only the tail part of the block
        r = $urandom_range(1, b.sz - 1);
        send_item(FN_FREE, b.sz - r, b.off + r);
      end else begin
        send_item(FN_FREE, b.sz, b.off);
      end
    end else if ($urandom_range(0, 1) == 0) begin
      send_item(FN_FREE, $urandom_range(0, lim), $urandom_range(0, rsz));
    end else begin
      send_item(FN_FREE, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [31:0] sizes[5];
    sizes = '{32'd1, 32'd256, 32'hFFFF_FFFF, 32'd4096, 32'd1000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default region of 65536
    send_item(FN_ALLOC, 32'd0, 32'd0);
    send_item(FN_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_item(FN_ALLOC, 32'd100, 32'd0);
    send_item(FN_ALLOC, 32'd100, 32'd0);
    send_item(FN_ALLOC, 32'd100, 32'd0);
    send_item(FN_FREE, 32'd100, 32'd100);
    send_item(FN_FREE, 32'd100, 32'd0);
    send_item(FN_FREE, 32'd100, 32'd200);
    send_item(FN_FREE, 32'd50, 32'd10);
    send_item(FN_FREE, 32'd1, 32'd65536);
    send_item(FN_FREE, 32'd1, 32'd65537);
    send_item(FN_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FN_FREE, 32'd0, 32'd5);
    send_item(FN_ALLOC, 32'd65536, 32'd0);
    send_item(FN_ALLOC, 32'd1, 32'd0);
    send_item(FN_FREE, 32'd65536, 32'd0);
    send_item(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FN_CLEAR, 32'd0, 32'd0);

    // exhaust the node pool with scattered single-unit frees
    set_region(32'd256);
    for (int i = 0; i < 128; i++) send_item(FN_ALLOC, 32'd1, 32'd0);
    for (int i = 0; i < 66; i++) send_item(FN_FREE, 32'd1, 2 * i);
    live_q.delete();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) set_region(sizes[p - 1]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        random_item(p == 0 ? 32'd256 : sizes[p - 1]);
      end
    end
    no_gaps = 1'b0;
    drain();
    repeat (100) @(posedge clk);

    $display("Ran %0d items over %0d region sizes (1 to 2^32-1), %0d results checked",
             items_sent, settings_used + 1, results_seen);
    $display("Covered fits, merges, overlap, range, no-fit and pool-full cases");
    if (fails == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
